>>> rtl/prr_pkg.sv
// Package for the peer relay route selector: field widths, codes and the
// structs passed between the controller, the slot table and the top level.
// Depends on nothing.
package prr_pkg;

    localparam int ID_W       = 64;
    localparam int GEN_W      = 32;
    localparam int MASK_W     = 8;
    localparam int IDX_W      = 3;
    localparam int ST_W       = 3;
    localparam int HOP_W      = 2;
    localparam int EPOCH_W    = 32;
    localparam int AC_W       = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ROUTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EPOCH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b1;

    localparam logic [HOP_W-1:0] HOPS_NONE   = 2'd0;
    localparam logic [HOP_W-1:0] HOPS_DIRECT = 2'd2;
    localparam logic [HOP_W-1:0] HOPS_RELAY  = 2'd3;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_STALE_EPOCH = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_STALE_GEN   = 3'd4,
        ST_UNREACHABLE = 3'd5
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [GEN_W-1:0]  gen;
        logic [MASK_W-1:0] mask;
    } slot_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        slot_t            slot;
    } tbl_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } tbl_rd_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        slot_t            slot;
    } tbl_rsp_t;

    typedef struct packed {
        status_t           status;
        logic [HOP_W-1:0]  hop_nodes;
        logic [ID_W-1:0]   relay_id;
        logic [GEN_W-1:0]  relay_gen;
        logic              admissible;
    } out_item_t;

endpackage

>>> rtl/prr_if.sv
// Channel interfaces for the route selector: command requests and results.
// Depends on prr_pkg for the field widths.
interface prr_req_if;
    import prr_pkg::*;
    logic                command;
    logic [IDX_W-1:0]    entry_index;
    logic [ID_W-1:0]     entry_id;
    logic [GEN_W-1:0]    entry_generation;
    logic [MASK_W-1:0]   entry_reach_mask;
    logic [EPOCH_W-1:0]  query_epoch;
    logic [ID_W-1:0]     source_id;
    logic [GEN_W-1:0]    source_gen;
    logic [ID_W-1:0]     dest_id;
    logic [GEN_W-1:0]    dest_gen;
    logic                valid;
    logic                ready;

    modport source (output command, entry_index, entry_id, entry_generation,
                    entry_reach_mask, query_epoch, source_id, source_gen, dest_id,
                    dest_gen, valid, input ready);
    modport sink (input command, entry_index, entry_id, entry_generation,
                  entry_reach_mask, query_epoch, source_id, source_gen, dest_id,
                  dest_gen, valid, output ready);
endinterface

interface prr_rsp_if;
    import prr_pkg::*;
    logic [ST_W-1:0]   status;
    logic [HOP_W-1:0]  hop_nodes;
    logic [ID_W-1:0]   relay_id;
    logic [GEN_W-1:0]  relay_gen;
    logic              admissible;
    logic              valid;
    logic              ready;

    modport source (output status, hop_nodes, relay_id, relay_gen, admissible, valid,
                    input ready);
    modport sink (input status, hop_nodes, relay_id, relay_gen, admissible, valid,
                  output ready);
endinterface

>>> rtl/peer_relay_route_select.sv
// Channel   Dir  Width of payload   Transfer when
// req       in   command fields     req.valid && req.ready
// rsp       out  result fields      rsp.valid && rsp.ready
// cfg       in   idx 1, data 32     cfg_we
// Each item is accepted, then the slot table is swept through its single registered
// read port, then the slots are walked for the relay, and the result is handed to the
// output register.
// Reset clears the table valid bits, so every slot reads as zero until written.
// A stalled result is held in the output register; the next request is taken meanwhile
// and waits at its end until the register is free.
// Depends on prr_pkg, prr_if, prr_table and prr_ctrl.
module peer_relay_route_select #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    prr_req_if.sink                           req,
    prr_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [prr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import prr_pkg::*;

    logic [EPOCH_W-1:0] epoch_reg;
    logic [AC_W-1:0]    ac_reg;
    tbl_wr_t            tbl_wr;
    tbl_rd_t            tbl_rd;
    tbl_rsp_t           tbl_rsp;
    out_item_t          res;
    logic               res_valid;
    logic               res_ready;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    prr_table #(.MAX_SLOTS(MAX_SLOTS)) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .rd    (tbl_rd),
        .rsp   (tbl_rsp)
    );

    prr_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .epoch        (epoch_reg),
        .active_count (ac_reg),
        .req          (req),
        .tbl_wr       (tbl_wr),
        .tbl_rd       (tbl_rd),
        .tbl_rsp      (tbl_rsp),
        .res          (res),
        .res_valid    (res_valid),
        .res_ready    (res_ready)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg     <= '0;
            ac_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_EPOCH:  epoch_reg <= cfg_wdata[EPOCH_W-1:0];
                    CFG_ACTIVE: ac_reg    <= cfg_wdata[AC_W-1:0];
                    default:    ;
                endcase
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_item_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_item_reg.status;
    assign rsp.hop_nodes  = out_item_reg.hop_nodes;
    assign rsp.relay_id   = out_item_reg.relay_id;
    assign rsp.relay_gen  = out_item_reg.relay_gen;
    assign rsp.admissible = out_item_reg.admissible;

endmodule

>>> rtl/prr_table.sv
// Slot table memory with one write port and one registered read port.
// Unwritten slots read as zero through per-slot valid bits. Depends on prr_pkg.
module prr_table #(
    parameter int MAX_SLOTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  prr_pkg::tbl_wr_t   wr,
    input  prr_pkg::tbl_rd_t   rd,
    output prr_pkg::tbl_rsp_t  rsp
);
    import prr_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    slot_t                 mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  vld_reg;
    slot_t                 rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rsp_valid_reg;
    logic [IDX_W-1:0]      rsp_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[SLOT_W-1:0]] <= wr.slot;
        end
        rd_data_reg <= mem[rd.addr[SLOT_W-1:0]];
        rsp_idx_reg <= rd.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr[SLOT_W-1:0]] <= 1'b1;
            end
            rd_vld_reg    <= vld_reg[rd.addr[SLOT_W-1:0]];
            rsp_valid_reg <= rd.en;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.idx   = rsp_idx_reg;
    assign rsp.slot  = rd_vld_reg ? rd_data_reg : '0;

endmodule

>>> rtl/prr_ctrl.sv
// Sequencer: writes the slot table, sweeps it for validity and endpoint lookup,
// then walks the slots for the lowest-id relay. Depends on prr_pkg, prr_if.
module prr_ctrl #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [prr_pkg::EPOCH_W-1:0]     epoch,
    input  logic [prr_pkg::AC_W-1:0]        active_count,
    prr_req_if.sink                         req,
    output prr_pkg::tbl_wr_t                tbl_wr,
    output prr_pkg::tbl_rd_t                tbl_rd,
    input  prr_pkg::tbl_rsp_t               tbl_rsp,
    output prr_pkg::out_item_t              res,
    output logic                            res_valid,
    input  logic                            res_ready
);
    import prr_pkg::*;

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SWEEP = 4'b0010,
        S_RELAY = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 ok_reg;
    logic                 s_found_reg;
    logic                 d_found_reg;
    logic                 gen_bad_reg;
    logic                 best_found_reg;

    logic                 cmd_reg;
    logic [EPOCH_W-1:0]   qep_reg;
    logic [ID_W-1:0]      sid_reg;
    logic [GEN_W-1:0]     sgen_reg;
    logic [ID_W-1:0]      did_reg;
    logic [GEN_W-1:0]     dgen_reg;
    logic [ID_W-1:0]      id_reg   [MAX_SLOTS];
    logic [GEN_W-1:0]     gen_reg  [MAX_SLOTS];
    logic [MASK_W-1:0]    mask_reg [MAX_SLOTS];
    logic [SLOT_W-1:0]    s_idx_reg;
    logic [SLOT_W-1:0]    d_idx_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [GEN_W-1:0]     best_gen_reg;
    logic                 adm_reg;

    logic                 acc;
    logic                 entry_act;
    logic                 entry_dup;
    logic                 entry_ok;
    logic                 src_hit;
    logic                 dst_hit;
    logic [MASK_W-1:0]    hi_bits;
    logic                 ok_final;
    logic [SLOT_W-1:0]    ci;
    logic                 cand;
    logic                 better;
    logic                 relay_last;
    logic                 adm_comb;
    logic                 pair_any;

    function automatic logic link(input logic [MASK_W-1:0] ma, input logic [MASK_W-1:0] mb,
                                  input logic [SLOT_W-1:0] a, input logic [SLOT_W-1:0] b);
        return ma[b] & mb[a];
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign acc       = req.valid && req.ready;

    assign tbl_wr.en        = acc && (req.command == CMD_WRITE) &&
                              ({1'b0, req.entry_index} < AC_W'(MAX_SLOTS));
    assign tbl_wr.addr      = req.entry_index;
    assign tbl_wr.slot.id   = req.entry_id;
    assign tbl_wr.slot.gen  = req.entry_generation;
    assign tbl_wr.slot.mask = req.entry_reach_mask;

    assign tbl_rd.en   = (state_reg == S_SWEEP) && (cnt_reg < CNT_W'(MAX_SLOTS));
    assign tbl_rd.addr = IDX_W'(cnt_reg);

    always_comb
    begin
        hi_bits   = MASK_W'({MASK_W{1'b1}} << active_count);
        entry_act = ({1'b0, tbl_rsp.idx} < active_count);
        entry_dup = 1'b0;
        for (int k = 0; k < MAX_SLOTS; k++)
        begin
            if ((IDX_W'(k) < tbl_rsp.idx) && (id_reg[k] == tbl_rsp.slot.id))
            begin
                entry_dup = 1'b1;
            end
        end
        if (entry_act)
        begin
            entry_ok = (tbl_rsp.slot.id != '0) && (tbl_rsp.slot.gen != '0) &&
                       !tbl_rsp.slot.mask[tbl_rsp.idx] &&
                       ((tbl_rsp.slot.mask & hi_bits) == '0) && !entry_dup;
        end
        else
        begin
            entry_ok = (tbl_rsp.slot == '0);
        end
        src_hit = entry_act && (tbl_rsp.slot.id == sid_reg) && !s_found_reg;
        dst_hit = entry_act && (tbl_rsp.slot.id == did_reg) && !d_found_reg;
    end

    assign ok_final = ok_reg && (epoch != '0) && (active_count >= AC_W'(2)) &&
                      (active_count <= AC_W'(MAX_SLOTS));

    assign ci         = cnt_reg[SLOT_W-1:0];
    assign cand       = (AC_W'(cnt_reg) < active_count) && (ci != s_idx_reg) &&
                        (ci != d_idx_reg) &&
                        link(mask_reg[s_idx_reg], mask_reg[ci], s_idx_reg, ci) &&
                        link(mask_reg[ci], mask_reg[d_idx_reg], ci, d_idx_reg);
    assign better     = !best_found_reg || (id_reg[ci] < best_id_reg);
    assign relay_last = (cnt_reg == CNT_W'(MAX_SLOTS - 1));

    always_comb
    begin
        adm_comb = ok_final;
        for (int a = 0; a < MAX_SLOTS; a++)
        begin
            for (int b = 0; b < MAX_SLOTS; b++)
            begin
                pair_any = link(mask_reg[a], mask_reg[b], SLOT_W'(a), SLOT_W'(b));
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    pair_any = pair_any |
                               (link(mask_reg[a], mask_reg[i], SLOT_W'(a), SLOT_W'(i)) &
                                link(mask_reg[i], mask_reg[b], SLOT_W'(i), SLOT_W'(b)));
                end
                if ((a < b) && (AC_W'(b) < active_count) && !pair_any)
                begin
                    adm_comb = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            ok_reg         <= 1'b0;
            s_found_reg    <= 1'b0;
            d_found_reg    <= 1'b0;
            gen_bad_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        state_reg   <= S_SWEEP;
                        cnt_reg     <= '0;
                        ok_reg      <= 1'b1;
                        s_found_reg <= 1'b0;
                        d_found_reg <= 1'b0;
                        gen_bad_reg <= 1'b0;
                    end
                end
                S_SWEEP:
                begin
                    if (cnt_reg < CNT_W'(MAX_SLOTS))
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                    if (tbl_rsp.valid)
                    begin
                        ok_reg <= ok_reg & entry_ok;
                        if (src_hit)
                        begin
                            s_found_reg <= 1'b1;
                        end
                        if (dst_hit)
                        begin
                            d_found_reg <= 1'b1;
                        end
                        if ((src_hit && (tbl_rsp.slot.gen != sgen_reg)) ||
                            (dst_hit && (tbl_rsp.slot.gen != dgen_reg)))
                        begin
                            gen_bad_reg <= 1'b1;
                        end
                        if (tbl_rsp.idx == IDX_W'(MAX_SLOTS - 1))
                        begin
                            state_reg      <= S_RELAY;
                            cnt_reg        <= '0;
                            best_found_reg <= 1'b0;
                        end
                    end
                end
                S_RELAY:
                begin
                    if (cand && better)
                    begin
                        best_found_reg <= 1'b1;
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (relay_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd_reg  <= req.command;
            qep_reg  <= req.query_epoch;
            sid_reg  <= req.source_id;
            sgen_reg <= req.source_gen;
            did_reg  <= req.dest_id;
            dgen_reg <= req.dest_gen;
        end
        if ((state_reg == S_SWEEP) && tbl_rsp.valid)
        begin
            id_reg[tbl_rsp.idx[SLOT_W-1:0]]   <= tbl_rsp.slot.id;
            gen_reg[tbl_rsp.idx[SLOT_W-1:0]]  <= tbl_rsp.slot.gen;
            mask_reg[tbl_rsp.idx[SLOT_W-1:0]] <= tbl_rsp.slot.mask;
            if (src_hit)
            begin
                s_idx_reg <= tbl_rsp.idx[SLOT_W-1:0];
            end
            if (dst_hit)
            begin
                d_idx_reg <= tbl_rsp.idx[SLOT_W-1:0];
            end
        end
        if (state_reg == S_RELAY)
        begin
            if (cand && better)
            begin
                best_id_reg  <= id_reg[ci];
                best_gen_reg <= gen_reg[ci];
            end
            if (relay_last)
            begin
                adm_reg <= adm_comb;
            end
        end
    end

    always_comb
    begin
        res.status     = ST_OK;
        res.hop_nodes  = HOPS_NONE;
        res.relay_id   = '0;
        res.relay_gen  = '0;
        res.admissible = adm_reg;
        if (cmd_reg == CMD_ROUTE)
        begin
            if (!ok_final || (sid_reg == '0) || (did_reg == '0) || (sid_reg == did_reg))
            begin
                res.status = ST_INVALID;
            end
            else if (qep_reg != epoch)
            begin
                res.status = ST_STALE_EPOCH;
            end
            else if (!s_found_reg || !d_found_reg)
            begin
                res.status = ST_NOT_FOUND;
            end
            else if (gen_bad_reg)
            begin
                res.status = ST_STALE_GEN;
            end
            else if (link(mask_reg[s_idx_reg], mask_reg[d_idx_reg], s_idx_reg, d_idx_reg))
            begin
                res.hop_nodes = HOPS_DIRECT;
            end
            else if (best_found_reg)
            begin
                res.hop_nodes = HOPS_RELAY;
                res.relay_id  = best_id_reg;
                res.relay_gen = best_gen_reg;
            end
            else
            begin
                res.status = ST_UNREACHABLE;
            end
        end
    end

    assign res_valid = (state_reg == S_DONE);

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (cmd_reg == CMD_WRITE)) |-> (res.status == ST_OK))
        else $error("A table write produced a non-ok status.");

    a_rsp_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_rsp.valid |-> (state_reg == S_SWEEP))
        else $error("Table read data arrived outside the sweep.");

    a_relay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.hop_nodes == HOPS_RELAY)) |-> (res.relay_id != '0))
        else $error("A relayed route names a relay with a zero id.");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_wr.en |-> $past(state_reg != S_SWEEP) || (state_reg == S_IDLE))
        else $error("The table was written during a sweep.");

endmodule

>>> test/peer_relay_route_select_test.sv
// Self-checking testbench for peer_relay_route_select: drives table writes and route
// queries with random idling on both channels and checks each result transfer.
// Depends on prr_pkg, prr_if and the peer_relay_route_select RTL.
`timescale 1ns / 100ps

module peer_relay_route_select_test;
    import prr_pkg::*;

    localparam int SLOTS = 8;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 40;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   entry_index;
        logic [ID_W-1:0]    entry_id;
        logic [GEN_W-1:0]   entry_generation;
        logic [MASK_W-1:0]  entry_reach_mask;
        logic [EPOCH_W-1:0] query_epoch;
        logic [ID_W-1:0]    source_id;
        logic [GEN_W-1:0]   source_gen;
        logic [ID_W-1:0]    dest_id;
        logic [GEN_W-1:0]   dest_gen;
    } route_req_t;

    class route_scoreboard;
        logic [ID_W-1:0]    ids[SLOTS];
        logic [GEN_W-1:0]   gens[SLOTS];
        logic [MASK_W-1:0]  masks[SLOTS];
        logic [EPOCH_W-1:0] epoch;
        logic [AC_W-1:0]    active;
        out_item_t          pending_results[$];
        int                 errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                ids[i] = '0;
                gens[i] = '0;
                masks[i] = '0;
            end
            epoch = '0;
            active = '0;
            errors = 0;
        endfunction

        function bit table_ok();
            if (epoch == 0 || active < 2 || active > SLOTS)
                return 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (i >= active)
                begin
                    if (ids[i] != 0 || gens[i] != 0 || masks[i] != 0)
                        return 0;
                    continue;
                end
                if (ids[i] == 0 || gens[i] == 0 || masks[i][i])
                    return 0;
                if ((16'(masks[i]) >> active) != 0)
                    return 0;
                for (int k = 0; k < i; k++)
                    if (ids[k] == ids[i])
                        return 0;
            end
            return 1;
        endfunction

        function bit linked(int a, int b);
            return masks[a][b] && masks[b][a];
        endfunction

        function int lowest_relay(int s, int d);
            int best;
            best = -1;
            for (int i = 0; i < active && i < SLOTS; i++)
            begin
                if (i == s || i == d || !linked(s, i) || !linked(i, d))
                    continue;
                if (best < 0 || ids[i] < ids[best])
                    best = i;
            end
            return best;
        endfunction

        function bit all_pairs_connect();
            if (!table_ok())
                return 0;
            for (int a = 0; a < active; a++)
                for (int b = a + 1; b < active; b++)
                    if (!linked(a, b) && lowest_relay(a, b) < 0)
                        return 0;
            return 1;
        endfunction

        function int slot_of(logic [ID_W-1:0] id);
            for (int i = 0; i < active && i < SLOTS; i++)
                if (ids[i] == id)
                    return i;
            return -1;
        endfunction

        function void note_request(route_req_t it);
            out_item_t r;
            int s, d, rl;
            r = '{status: ST_OK, hop_nodes: HOPS_NONE, relay_id: '0, relay_gen: '0,
                  admissible: 1'b0};
            if (it.command == CMD_WRITE)
            begin
                ids[it.entry_index] = it.entry_id;
                gens[it.entry_index] = it.entry_generation;
                masks[it.entry_index] = it.entry_reach_mask;
            end
            else if (!table_ok() || it.source_id == 0 || it.dest_id == 0
                     || it.source_id == it.dest_id)
                r.status = ST_INVALID;
            else if (it.query_epoch != epoch)
                r.status = ST_STALE_EPOCH;
            else
            begin
                s = slot_of(it.source_id);
                d = slot_of(it.dest_id);
                if (s < 0 || d < 0)
                    r.status = ST_NOT_FOUND;
                else if (gens[s] != it.source_gen || gens[d] != it.dest_gen)
                    r.status = ST_STALE_GEN;
                else if (linked(s, d))
                    r.hop_nodes = HOPS_DIRECT;
                else
                begin
                    rl = lowest_relay(s, d);
                    if (rl < 0)
                        r.status = ST_UNREACHABLE;
                    else
                    begin
                        r.hop_nodes = HOPS_RELAY;
                        r.relay_id = ids[rl];
                        r.relay_gen = gens[rl];
                    end
                end
            end
            r.admissible = all_pairs_connect();
            pending_results.push_back(r);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no result expected");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.hop_nodes !== want.hop_nodes)
            begin
                $error("hop_nodes: expected %0d, got %0d", want.hop_nodes, got.hop_nodes);
                errors++;
            end
            if (got.relay_id !== want.relay_id)
            begin
                $error("relay_id: expected %h, got %h", want.relay_id, got.relay_id);
                errors++;
            end
            if (got.relay_gen !== want.relay_gen)
            begin
                $error("relay_gen: expected %h, got %h", want.relay_gen, got.relay_gen);
                errors++;
            end
            if (got.admissible !== want.admissible)
            begin
                $error("admissible: expected %0d, got %0d", want.admissible, got.admissible);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int cycles;
    bit steady;
    int stall_left;
    route_scoreboard sb;

    prr_req_if req ();
    prr_rsp_if rsp ();

    peer_relay_route_select #(.MAX_SLOTS(SLOTS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("peer_relay_route_select test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_result('{status: status_t'(rsp.status), hop_nodes: rsp.hop_nodes,
                                  relay_id: rsp.relay_id, relay_gen: rsp.relay_gen,
                                  admissible: rsp.admissible});
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                stall_left <= pick_gap();
                rsp.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(input route_req_t it);
        int g;
        req.valid <= 1'b1;
        req.command <= it.command;
        req.entry_index <= it.entry_index;
        req.entry_id <= it.entry_id;
        req.entry_generation <= it.entry_generation;
        req.entry_reach_mask <= it.entry_reach_mask;
        req.query_epoch <= it.query_epoch;
        req.source_id <= it.source_id;
        req.source_gen <= it.source_gen;
        req.dest_id <= it.dest_id;
        req.dest_gen <= it.dest_gen;
        do @(posedge clk); while (!req.ready);
        sb.note_request(it);
        g = pick_gap();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_EPOCH)
            sb.epoch = value;
        else
            sb.active = value[AC_W-1:0];
    endtask

    function automatic route_req_t noise_req();
        route_req_t it;
        logic [351:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(route_req_t)-1:0];
        return it;
    endfunction

    function automatic route_req_t slot_write(int idx, logic [ID_W-1:0] id,
                                              logic [GEN_W-1:0] gen, logic [7:0] mask);
        route_req_t it;
        it = noise_req();
        it.command = CMD_WRITE;
        it.entry_index = IDX_W'(idx);
        it.entry_id = id;
        it.entry_generation = gen;
        it.entry_reach_mask = mask;
        return it;
    endfunction

    function automatic route_req_t route_query(logic [ID_W-1:0] sid, logic [GEN_W-1:0] sg,
                                               logic [ID_W-1:0] did, logic [GEN_W-1:0] dg,
                                               logic [EPOCH_W-1:0] ep);
        route_req_t it;
        it = noise_req();
        it.command = CMD_ROUTE;
        it.query_epoch = ep;
        it.source_id = sid;
        it.source_gen = sg;
        it.dest_id = did;
        it.dest_gen = dg;
        return it;
    endfunction

    task automatic load_table(input int n, input int density);
        logic [ID_W-1:0] id;
        logic [7:0] mask;
        bit clash;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i < n)
            begin
                do
                begin
                    id = $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                   : 64'($urandom_range(1, 40));
                    clash = (id == 0);
                    for (int k = 0; k < i; k++)
                        if (sb.ids[k] == id)
                            clash = 1;
                end
                while (clash);
                mask = '0;
                for (int j = 0; j < n; j++)
                    if (j != i && $urandom_range(0, 99) < density)
                        mask[j] = 1'b1;
                if ($urandom_range(0, 49) == 0)
                    mask = 8'($urandom);
                send_request(slot_write(i, id, $urandom_range(0, 9) == 0 ? 32'hffffffff
                                        : $urandom_range(1, 1000), mask));
            end
            else if ($urandom_range(0, 29) == 0)
                send_request(slot_write(i, {$urandom, $urandom}, $urandom, 8'($urandom)));
            else
                send_request(slot_write(i, '0, '0, '0));
        end
    endtask

    task automatic query_burst(input int count, input int n);
        route_req_t it;
        int s, d;
        for (int q = 0; q < count; q++)
        begin
            s = $urandom_range(0, n > 0 ? n - 1 : 0);
            d = $urandom_range(0, n > 0 ? n - 1 : 0);
            if (n >= 2)
                while (d == s)
                    d = $urandom_range(0, n - 1);
            it = route_query(sb.ids[s], sb.gens[s], sb.ids[d], sb.gens[d], sb.epoch);
            case ($urandom_range(0, 19))
                0: it.query_epoch = $urandom;
                1: it.source_id = {$urandom, $urandom};
                2: it.dest_id = 64'($urandom_range(41, 60));
                3: it.source_gen = $urandom;
                4: it.dest_gen = sb.gens[d] ^ (32'h1 << $urandom_range(0, 31));
                5: it.dest_id = it.source_id;
                6: it.source_id = '0;
                7: it = noise_req();
                8: it = slot_write(int'($urandom_range(0, 7)), {$urandom, $urandom},
                                   $urandom, 8'($urandom));
                default: ;
            endcase
            send_request(it);
        end
    endtask

    initial
    begin
        int n;
        logic [31:0] ep;
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        steady = 0;
        stall_left = 0;
        cfg_we = 1'b0;
        cfg_idx = CFG_EPOCH;
        cfg_wdata = '0;
        rsp.ready = 1'b0;
        req.valid = 1'b0;
        {req.command, req.entry_index, req.entry_id, req.entry_generation,
         req.entry_reach_mask, req.query_epoch, req.source_id, req.source_gen,
         req.dest_id, req.dest_gen} = '0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(route_query(64'd1, 32'd1, 64'd2, 32'd1, '0));
        drain();
        write_reg(CFG_EPOCH, 32'hffffffff);
        write_reg(CFG_ACTIVE, 4);
        send_request(slot_write(0, 64'hffffffffffffffff, 32'hffffffff, 8'b0000_1010));
        send_request(slot_write(1, 64'd5, 32'd1, 8'b0000_0101));
        send_request(slot_write(2, 64'd3, 32'd7, 8'b0000_1010));
        send_request(slot_write(3, 64'd9, 32'd2, 8'b0000_0101));
        send_request(route_query(64'hffffffffffffffff, 32'hffffffff, 64'd5, 32'd1,
                                 32'hffffffff));
        send_request(route_query(64'hffffffffffffffff, 32'hffffffff, 64'd3, 32'd7,
                                 32'hffffffff));
        send_request(route_query(64'd5, 32'd1, 64'd9, 32'd2, 32'hffffffff));
        send_request(route_query(64'd5, 32'd1, 64'd9, 32'd2, 32'd1));
        send_request(route_query(64'd5, 32'd1, 64'd77, 32'd2, 32'hffffffff));
        send_request(route_query(64'd5, 32'd2, 64'd9, 32'd2, 32'hffffffff));
        send_request(route_query(64'd5, 32'd1, 64'd5, 32'd1, 32'hffffffff));
        send_request(route_query(64'd0, 32'd1, 64'd9, 32'd2, 32'hffffffff));
        send_request(slot_write(1, 64'd5, 32'd1, 8'b0000_0000));
        send_request(route_query(64'd5, 32'd1, 64'd9, 32'd2, 32'hffffffff));
        send_request(slot_write(7, 64'hffffffffffffffff, 32'hffffffff, 8'hff));
        send_request(route_query(64'd3, 32'd7, 64'd9, 32'd2, 32'hffffffff));
        send_request(slot_write(7, '0, '0, '0));
        send_request(slot_write(0, 64'd9, 32'd1, 8'b0000_1010));
        send_request(route_query(64'd3, 32'd7, 64'd9, 32'd2, 32'hffffffff));
        drain();
        write_reg(CFG_EPOCH, '0);
        send_request(route_query(64'd3, 32'd7, 64'd9, 32'd2, 32'd0));
        drain();

        for (int phase = 0; phase < 15; phase++)
        begin
            case (phase)
                0, 6, 11: n = 8;
                1, 7: n = 2;
                2: n = 0;
                3: n = 1;
                4: n = 9;
                5: n = 15;
                default: n = $urandom_range(3, 7);
            endcase
            case (phase % 4)
                0: ep = 32'd1;
                1: ep = 32'hffffffff;
                2: ep = $urandom;
                default: ep = (phase == 3) ? 32'd0 : $urandom;
            endcase
            steady = (phase % 5 == 4);
            write_reg(CFG_EPOCH, ep);
            write_reg(CFG_ACTIVE, n);
            load_table(n > SLOTS ? SLOTS : n, $urandom_range(20, 80));
            query_burst(50, n > SLOTS ? SLOTS : n);
            load_table(n > SLOTS ? SLOTS : n, $urandom_range(30, 90));
            query_burst(45, n > SLOTS ? SLOTS : n);
            drain();
        end

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("peer_relay_route_select test passed");
        else
            $display("peer_relay_route_select test failed");
        $finish;
    end
endmodule
